>>> rtl/bbc_pkg.sv
package bbc_pkg;

    localparam int ENTRIES_DEF         = 64;
    localparam int MAX_BLOCK_WORDS_DEF = 64;
    localparam int CACHE_LIMIT         = 51;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_MISS = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic search;    // register the tag search result for the current word
        logic remove_hit;   // remove the entry found by the search
        logic evict;     // remove the oldest entry
        logic allocate;  // allocate the lowest free slot as the newest entry
        logic fill;      // write a data word to fill_slot
        logic rd_start;  // start reading word 0 of the hit slot
        logic rd_next;   // advance the read pointer
    } bbc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic full;
        logic fill_ok;
    } bbc_stat_t;

endpackage

>>> rtl/block_buffer_cache_top.sv
// A word is accepted only while the controller is idle. The tag search is registered
// before the result is chosen. An add at word 0 may first evict the oldest entry and
// remove an old copy of the block before it allocates; a read hit gives one result word
// per block word, and result stalls hold the block. Result words wait in a one-deep
// output register.
// Reset (aresetn low, synchronous) clears entry valid bits, count, fill slot, block_words=64.
module block_buffer_cache_top
    import bbc_pkg::*;
#(
    parameter int ENTRIES         = ENTRIES_DEF,
    parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,      // block_words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,        // opcode[1:0]
    input  logic [103:0] s_tdata,        // block_number[31:0], word_index[37:32],
                                         // data_in[101:38], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tuser,        // status[0]
    output logic [63:0]  m_tdata,        // data_out[63:0]
    output logic         m_tlast
);

    localparam int WW = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;

    logic [6:0]  words_reg;
    logic [31:0] blk_reg;
    logic [5:0]  wi_reg;
    logic [63:0] din_reg;
    bbc_cmd_t    cmd;
    bbc_stat_t   stat;
    logic [63:0] rd_data;
    logic        out_load, out_status, out_last, out_from_store;
    logic        mv_reg;
    logic        mstat_reg;
    logic [63:0] mdata_reg;
    logic        mlast_reg;
    logic        out_free;

    // The block_words register, loaded on cfg_we; the user must write it only while idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg <= 7'd64;
        end else if (cfg_we) begin
            words_reg <= cfg_wdata;
        end
    end

    // Capture the payload of an accepted word.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            blk_reg <= s_tdata[31:0];
            wi_reg  <= s_tdata[37:32];
            din_reg <= s_tdata[101:38];
        end
    end

    bbc_ctrl #(.MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .opcode         (s_tuser),
        .word_index     (s_tdata[37:32]),
        .words          (words_reg),
        .cmd            (cmd),
        .stat           (stat),
        .out_load       (out_load),
        .out_status     (out_status),
        .out_last       (out_last),
        .out_from_store (out_from_store),
        .out_free       (out_free)
    );

    bbc_datapath #(.ENTRIES(ENTRIES), .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .blk      (blk_reg),
        .word_idx (WW'(wi_reg)),
        .data_in  (din_reg),
        .rd_data  (rd_data)
    );

    // The output register frees when its word is taken.
    assign out_free = !mv_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (out_load) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
        if (out_load) begin
            mstat_reg <= out_status;
            mdata_reg <= out_from_store ? rd_data : 64'd0;
            mlast_reg <= out_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mstat_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

endmodule

>>> rtl/bbc_datapath.sv
module bbc_datapath
    import bbc_pkg::*;
#(
    parameter int ENTRIES         = ENTRIES_DEF,
    parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bbc_cmd_t                           cmd,
    output bbc_stat_t                          stat,
    input  logic [31:0]                        blk,
    input  logic [((MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1)-1:0] word_idx,
    input  logic [63:0]                        data_in,
    output logic [63:0]                        rd_data
);

    localparam int SW  = $clog2(ENTRIES);
    localparam int WW  = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int CAP = (ENTRIES < CACHE_LIMIT) ? ENTRIES : CACHE_LIMIT;
    localparam int AW  = SW + WW;

    logic [31:0]    tag_reg   [ENTRIES];
    logic [SW-1:0]  age_reg   [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [CW-1:0]  count_reg;
    logic [SW-1:0]  fill_slot_reg;
    logic           hit_reg;
    logic [SW-1:0]  hit_slot_reg;
    logic [WW-1:0]  rd_ptr_reg;
    logic [63:0]    store [ENTRIES * MAX_BLOCK_WORDS];
    logic [63:0]    rd_data_reg;

    // Per-entry match, free-slot and oldest-slot priority search.
    logic [ENTRIES-1:0] match;
    logic [SW-1:0]      match_slot;
    logic [SW-1:0]      free_slot;
    logic [SW-1:0]      old_slot;
    logic [SW-1:0]      cap_age;
    logic [SW-1:0]      rm_slot;
    logic               rm_en;
    logic [WW-1:0]      wr_word;
    logic [WW-1:0]      rd_word;

    assign cap_age = SW'(CAP - 1);

    always_comb begin
        match_slot = '0;
        free_slot  = '0;
        old_slot   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = valid_reg[i] && (tag_reg[i] == blk);
            if (match[i]) begin
                match_slot = SW'(i);
            end
            if (!valid_reg[i]) begin
                free_slot = SW'(i);
            end
            if (valid_reg[i] && age_reg[i] == cap_age) begin
                old_slot = SW'(i);
            end
        end
    end

    assign rm_en   = cmd.evict || (cmd.remove_hit && hit_reg);
    assign rm_slot = cmd.evict ? old_slot : hit_slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            count_reg     <= '0;
            fill_slot_reg <= '0;
            hit_reg       <= 1'b0;
        end else begin
            if (cmd.search) begin
                hit_reg      <= |match;
                hit_slot_reg <= match_slot;
            end
            if (rm_en) begin
                valid_reg[rm_slot] <= 1'b0;
                count_reg          <= count_reg - 1'b1;
                for (int j = 0; j < ENTRIES; j++) begin
                    if (valid_reg[j] && age_reg[j] > age_reg[rm_slot]) begin
                        age_reg[j] <= age_reg[j] - 1'b1;
                    end
                end
                hit_reg <= 1'b0;
            end else if (cmd.allocate) begin
                for (int j = 0; j < ENTRIES; j++) begin
                    if (valid_reg[j]) begin
                        age_reg[j] <= age_reg[j] + 1'b1;
                    end
                end
                valid_reg[free_slot] <= 1'b1;
                tag_reg[free_slot]   <= blk;
                age_reg[free_slot]   <= '0;
                count_reg            <= count_reg + 1'b1;
                fill_slot_reg        <= free_slot;
            end
        end
    end

    assign wr_word = cmd.allocate ? '0 : WW'(word_idx);
    assign rd_word = cmd.rd_start ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.allocate) begin
            store[AW'({free_slot, wr_word})] <= data_in;
        end else if (cmd.fill) begin
            store[AW'({fill_slot_reg, wr_word})] <= data_in;
        end
        if (cmd.rd_start || cmd.rd_next) begin
            rd_ptr_reg  <= rd_word;
            rd_data_reg <= store[AW'({hit_slot_reg, rd_word})];
        end
    end

    assign rd_data      = rd_data_reg;
    assign stat.hit     = hit_reg;
    assign stat.full    = count_reg >= CW'(CAP);
    assign stat.fill_ok = valid_reg[fill_slot_reg] && (tag_reg[fill_slot_reg] == blk);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAP))
        else $error("entry count above capacity");
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'($countones(valid_reg)) == count_reg)
        else $error("entry count disagrees with valid bits");
    a_alloc_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.allocate && !rm_en |=> valid_reg[fill_slot_reg])
        else $error("allocated slot not valid");

endmodule

>>> rtl/bbc_ctrl.sv
module bbc_ctrl
    import bbc_pkg::*;
#(
    parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [5:0]  word_index,
    input  logic [6:0]  words,
    output bbc_cmd_t    cmd,
    input  bbc_stat_t   stat,
    output logic        out_load,
    output logic        out_status,
    output logic        out_last,
    output logic        out_from_store,
    input  logic        out_free
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_EVICT  = 3'd2;
    localparam logic [2:0] S_ALLOC  = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_RWAIT  = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] op_reg;
    logic [5:0] wi_reg;
    logic [6:0] n_reg;
    logic [6:0] cnt_reg, cnt_next;
    logic       st_reg, st_next;
    logic [6:0] eff;

    assign eff = (words == 7'd0) ? 7'd1 :
                 (words > 7'(MAX_BLOCK_WORDS)) ? 7'(MAX_BLOCK_WORDS) : words;
    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            st_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
        end
        if (in_valid && in_ready) begin
            op_reg <= opcode;
            wi_reg <= word_index;
            n_reg  <= eff;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        st_next        = st_reg;
        cmd            = '0;
        out_load       = 1'b0;
        out_status     = st_reg;
        out_last       = 1'b1;
        out_from_store = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid && opcode != OP_UNUSED) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.search = 1'b1;
                case (op_reg)
                    OP_READ: begin
                        state_next = S_READ;
                    end
                    OP_DELETE: begin
                        state_next = S_EVICT;
                    end
                    default: begin
                        if (wi_reg == '0) begin
                            cmd.evict  = stat.full;
                            cmd.search = !stat.full;
                            state_next = stat.full ? S_EXEC : S_ALLOC;
                            if (stat.full) begin
                                // Evict first, then search again with a count below full.
                                state_next = S_EVICT;
                            end
                            st_next = ST_OK;
                        end else if ({1'b0, wi_reg} >= n_reg) begin
                            st_next    = ST_OK;
                            state_next = S_RESP;
                        end else begin
                            cmd.search = 1'b0;
                            cmd.fill   = stat.fill_ok;
                            st_next    = stat.fill_ok ? ST_OK : ST_MISS;
                            state_next = S_RESP;
                        end
                    end
                endcase
            end
            S_EVICT: begin
                if (op_reg == OP_DELETE) begin
                    cmd.remove_hit = 1'b1;
                    st_next        = stat.hit ? ST_OK : ST_MISS;
                    state_next     = S_RESP;
                end else begin
                    cmd.search = 1'b1;
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (stat.hit) begin
                    cmd.remove_hit = 1'b1;
                end else begin
                    cmd.allocate = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_READ: begin
                if (!stat.hit) begin
                    st_next    = ST_MISS;
                    state_next = S_RESP;
                end else begin
                    cmd.rd_start = 1'b1;
                    cnt_next     = 7'd1;
                    state_next   = S_RWAIT;
                end
            end
            S_RWAIT: begin
                out_status     = ST_OK;
                out_from_store = 1'b1;
                out_last       = (cnt_reg == n_reg);
                if (out_free) begin
                    out_load = 1'b1;
                    if (cnt_reg == n_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_next = 1'b1;
                        cnt_next    = cnt_reg + 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_one_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.evict && cmd.allocate))
        else $error("evict and allocate together");
    a_read_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RWAIT |-> cnt_reg <= n_reg && cnt_reg != 7'd0)
        else $error("read counter out of range");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> state_reg == S_IDLE || state_reg == S_RWAIT)
        else $error("result loaded in wrong state");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the block buffer cache.
// Input words go through a stream handshake. At the moment each word is accepted,
// a cache model in this file works out the result words that the word should cause.
// Those result words are queued. Each result word that leaves the block is compared,
// field by field, with the oldest queued one.
module testbench;
    import bbc_pkg::*;

    localparam int NSLOT = 64;
    localparam int MAXW = 64;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic        status;
        logic [63:0] data;
        logic        last;
    } result_t;

    // One row of the directed table. A want_status of -1 means the
    // expectation comes from the cache model.
    typedef struct {
        logic [1:0]  op;
        logic [31:0] blk;
        logic [5:0]  wi;
        logic [63:0] d;
        int          want_status;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [6:0]   cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         m_tuser;
    logic [63:0]  m_tdata;
    logic         m_tlast;

    block_buffer_cache_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // Model state of the cache. The written flags track which store words hold
    // data since reset, so the bench never reads one that was never filled.
    logic [31:0] c_tag [NSLOT];
    bit          c_valid [NSLOT];
    int          c_age [NSLOT];
    logic [63:0] c_store [NSLOT*MAXW];
    bit          c_written [NSLOT*MAXW];
    int          c_count = 0;
    int          c_fill = 0;
    logic [6:0]  c_words = 7'd64;

    result_t pending_results[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cycles = 0;
    int      quiet_cycles = 0;
    logic [31:0] tag_pool [16];

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int words_now();
        if (c_words == 0) return 1;
        if (c_words > MAXW) return MAXW;
        return c_words;
    endfunction

    function automatic int lookup(logic [31:0] blk);
        for (int i = 0; i < NSLOT; i++)
            if (c_valid[i] && c_tag[i] == blk) return i;
        return -1;
    endfunction

    function automatic void drop_slot(int s);
        int a;
        a = c_age[s];
        c_valid[s] = 0;
        if (c_count > 0) c_count--;
        for (int j = 0; j < NSLOT; j++)
            if (c_valid[j] && c_age[j] > a) c_age[j]--;
    endfunction

    function automatic void drop_oldest();
        int pick;
        int best;
        pick = -1;
        best = 0;
        for (int i = 0; i < NSLOT; i++)
            if (c_valid[i] && (pick < 0 || c_age[i] >= best)) begin
                pick = i;
                best = c_age[i];
            end
        if (pick >= 0) drop_slot(pick);
    endfunction

    function automatic void expect_word(logic st, logic [63:0] d, logic lst);
        result_t r;
        r.status = st;
        r.data = d;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    // Applies one accepted word to the model and queues the result words it causes.
    function automatic void cache_step(logic [1:0] op, logic [31:0] blk, logic [5:0] wi,
                                       logic [63:0] d);
        int n;
        int s;
        n = words_now();
        s = lookup(blk);
        case (op)
            OP_READ: begin
                if (s < 0) begin
                    expect_word(ST_MISS, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        expect_word(ST_OK, c_store[s*MAXW+i], i == n - 1);
                end
            end
            OP_DELETE: begin
                if (s < 0) begin
                    expect_word(ST_MISS, '0, 1'b1);
                end else begin
                    drop_slot(s);
                    expect_word(ST_OK, '0, 1'b1);
                end
            end
            OP_ADD: begin
                if (wi == 0) begin
                    if (c_count >= CACHE_LIMIT) drop_oldest();
                    s = lookup(blk);
                    if (s >= 0) drop_slot(s);
                    s = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (!c_valid[i] && s < 0) s = i;
                    for (int i = 0; i < NSLOT; i++)
                        if (c_valid[i]) c_age[i]++;
                    c_valid[s] = 1;
                    c_tag[s] = blk;
                    c_age[s] = 0;
                    c_count++;
                    c_fill = s;
                    c_store[s*MAXW] = d;
                    c_written[s*MAXW] = 1;
                    expect_word(ST_OK, '0, 1'b1);
                end else if (wi >= n) begin
                    expect_word(ST_OK, '0, 1'b1);
                end else if (c_valid[c_fill] && c_tag[c_fill] == blk) begin
                    c_store[c_fill*MAXW+wi] = d;
                    c_written[c_fill*MAXW+wi] = 1;
                    expect_word(ST_OK, '0, 1'b1);
                end else begin
                    expect_word(ST_MISS, '0, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // A read of a present block is only allowed when all its words hold data.
    // Otherwise the read is pointed at a block that is absent.
    function automatic logic [31:0] safe_read_tag(logic [31:0] blk);
        int s;
        logic [31:0] t;
        s = lookup(blk);
        if (s < 0) return blk;
        for (int i = 0; i < words_now(); i++)
            if (!c_written[s*MAXW+i]) begin
                t = $urandom;
                while (lookup(t) >= 0) t = $urandom;
                return t;
            end
        return blk;
    endfunction

    // Offers one word and waits until it is accepted. Idle gaps come first, so
    // tvalid stays high between back-to-back words.
    task automatic send_word(logic [1:0] op, logic [31:0] blk, logic [5:0] wi,
                             logic [63:0] d, int want_status);
        if (op == OP_READ) blk = safe_read_tag(blk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, d, wi, blk};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cache_step(op, blk, wi, d);
        if (want_status >= 0) pending_results[$].status = want_status[0];
    endtask

    // The register is written only once the block has gone quiet and no result is
    // pending. An unused opcode is accepted, leaves the block idle and causes no result.
    task automatic set_words(logic [6:0] v);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        c_words = v;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // This process sets the receiver's stalls and checks the result words. It also
    // runs the watchdog, which ends the run after too many cycles with no accepted word.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata !== want.data)
                    report_mismatch("data", m_tdata, want.data);
                if (m_tlast !== want.last)
                    report_mismatch("last", 64'(m_tlast), 64'(want.last));
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAIL block_buffer_cache_top");
            $finish;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sends about n words in well-formed runs: a full block add, reads and deletes
    // from a small set of tags, and some noise. A few runs break off early or use
    // the wrong tag.
    task automatic random_words(int n);
        int sent;
        int pick;
        int nw;
        logic [31:0] t;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            t = tag_pool[$urandom_range(15)];
            nw = words_now();
            if (pick < 55) begin
                send_word(OP_ADD, t, 6'd0, {$urandom, $urandom}, -1);
                sent++;
                for (int i = 1; i < nw; i++) begin
                    if ($urandom_range(19) == 0) break;
                    send_word(OP_ADD, ($urandom_range(24) == 0) ? t ^ 32'h1 : t, 6'(i),
                              {$urandom, $urandom}, -1);
                    sent++;
                end
            end else if (pick < 80) begin
                send_word(OP_READ, t, 6'($urandom), {$urandom, $urandom}, -1);
                sent++;
            end else if (pick < 90) begin
                send_word(OP_DELETE, t, 6'($urandom), {$urandom, $urandom}, -1);
                sent++;
            end else begin
                send_word(2'($urandom_range(3)), ($urandom_range(1) == 0) ? t : $urandom,
                          6'($urandom), {$urandom, $urandom}, -1);
                sent++;
            end
        end
    endtask

    row_t directed [$];

    initial begin
        for (int i = 0; i < 14; i++) tag_pool[i] = $urandom;
        tag_pool[14] = 32'h0;
        tag_pool[15] = 32'hFFFF_FFFF;

        // Directed table. In it, an all-ones block is added, then overwritten by
        // a re-add, so its second word is left stale.
        directed = '{
            '{OP_READ,   32'h0,         6'd0,  64'h0,                  ST_MISS},
            '{OP_DELETE, 32'hFFFF_FFFF, 6'd0,  64'h0,                  ST_MISS},
            '{OP_ADD,    32'hFFFF_FFFF, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF, ST_OK},
            '{OP_ADD,    32'hFFFF_FFFF, 6'd1,  64'h0,                  ST_OK},
            '{OP_ADD,    32'hFFFF_FFFF, 6'd63, 64'h1234,               ST_OK},
            '{OP_READ,   32'hFFFF_FFFF, 6'd0,  64'h0,                  -1},
            '{OP_ADD,    32'h0,         6'd1,  64'h1,                  ST_MISS},
            '{OP_ADD,    32'h0,         6'd0,  64'hA5A5_A5A5_A5A5_A5A5, ST_OK},
            '{OP_ADD,    32'h0,         6'd1,  64'h5A5A_5A5A_5A5A_5A5A, ST_OK},
            '{OP_READ,   32'h0,         6'd63, 64'hFFFF_FFFF_FFFF_FFFF, -1},
            '{OP_ADD,    32'hFFFF_FFFF, 6'd1,  64'h7,                  ST_MISS},
            '{OP_ADD,    32'hFFFF_FFFF, 6'd0,  64'h8000_0000_0000_0001, ST_OK},
            '{OP_READ,   32'hFFFF_FFFF, 6'd0,  64'h0,                  -1},
            '{OP_UNUSED, 32'h0,         6'd0,  64'h0,                  -1},
            '{OP_DELETE, 32'h0,         6'd0,  64'h0,                  ST_OK},
            '{OP_READ,   32'h0,         6'd0,  64'h0,                  ST_MISS},
            '{OP_DELETE, 32'h0,         6'd0,  64'h0,                  ST_MISS}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_words(7'd2);
        foreach (directed[i])
            send_word(directed[i].op, directed[i].blk, directed[i].wi, directed[i].d,
                      directed[i].want_status);

        // A zero register acts as one word, and 127 acts as the full 64, so the
        // last word position of a block is still stored.
        set_words(7'd0);
        send_word(OP_READ, 32'hFFFF_FFFF, 6'd0, 64'd0, -1);
        set_words(7'd127);
        send_word(OP_ADD, 32'h55, 6'd0, 64'h1, ST_OK);
        send_word(OP_ADD, 32'h55, 6'd63, 64'h3F, ST_OK);

        // Fill past capacity so that the oldest entries are evicted. After that, a
        // block that is still present is added again while the cache is full.
        set_words(7'd1);
        for (int i = 0; i < 52; i++)
            send_word(OP_ADD, 32'h1000_0000 + i, 6'd0, {$urandom, $urandom}, -1);
        send_word(OP_ADD, 32'h1000_0030, 6'd0, 64'hDEAD, -1);
        send_word(OP_READ, 32'h1000_0000, 6'd0, 64'd0, -1);
        send_word(OP_READ, 32'h1000_0033, 6'd0, 64'd0, -1);
        send_word(OP_READ, 32'h1000_0030, 6'd0, 64'd0, -1);

        // Random phases with different idle patterns and block sizes.
        set_words(7'd3);
        random_words(7);
        send_idle_pct = 87;
        set_words(7'd1);
        random_words(7);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        set_words(7'd4);
        random_words(7);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        set_words(7'd2);
        random_words(7);

        // The receiver holds off for a long stretch while words keep coming, so
        // the block fills up and stalls its input.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_words(7'd5);
        hold_cycles = 400;
        random_words(8);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("PASS block_buffer_cache_top");
        else
            $display("FAIL block_buffer_cache_top");
        $finish;
    end
endmodule
